// ===== rtl/pfru_pkg.sv =====
// Shared constants, codes and types of the page frame replacement unit.
package pfru_pkg;

	localparam int NUM_FRAMES_DEF = 32;

	// item codes
	localparam logic [2:0] FUNC_WRITE  = 3'd0;
	localparam logic [2:0] FUNC_CLRREF = 3'd1;
	localparam logic [2:0] FUNC_VICTIM = 3'd2;
	localparam logic [2:0] FUNC_UPDWS  = 3'd3;
	localparam logic [2:0] FUNC_FIND   = 3'd4;

	// victim policies
	localparam logic [1:0] POL_NRU   = 2'd0;
	localparam logic [1:0] POL_CLOCK = 2'd1;
	localparam logic [1:0] POL_WSET  = 2'd2;

	// register index (paddr[2])
	localparam logic REG_POLICY = 1'b0;
	localparam logic REG_WINDOW = 1'b1;

	// entry word kept in the table memory: page, owner, last use
	localparam int ENTRY_W = 64;

	typedef enum logic [9:0] {
		ST_IDLE  = 10'b00_0000_0001,
		ST_NRU   = 10'b00_0000_0010,
		ST_FIND  = 10'b00_0000_0100,
		ST_WSV   = 10'b00_0000_1000,
		ST_UPD   = 10'b00_0001_0000,
		ST_CCNT  = 10'b00_0010_0000,
		ST_CRED  = 10'b00_0100_0000,
		ST_CSEEK = 10'b00_1000_0000,
		ST_CWALK = 10'b01_0000_0000,
		ST_DONE  = 10'b10_0000_0000
	} state_t;

endpackage

// ===== rtl/page_frame_replacement_unit_top.sv =====
// Top level of the page frame replacement unit.
// The unit keeps a table of NUM_FRAMES page frames and serves one item at a time.
// Page number, owner and last-use time live in a single-port-read memory; the
// occupied, referenced and modified bits sit in flip-flops so that reset and the
// clear-referenced item take effect at once. Find, working-set update and
// working-set victim sweep the memory one entry a cycle. NRU sweeps the flag
// bits. Clock victim counts the occupied frames, reduces the hand by repeated
// subtraction, seeks the hand's frame and walks the ring clearing referenced
// bits. A finished result waits in the output register; the next item is
// taken once the unit is back to idle.
module page_frame_replacement_unit_top #(
	parameter int NUM_FRAMES = pfru_pkg::NUM_FRAMES_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	// func[2:0], frame_index[7:3], occupied[8], page_number[24:9],
	// process_id[40:25], referenced[41], modified[42], last_use[74:43],
	// current_time[106:75], zero pad [111:107]
	input  logic [111:0] s_tdata,
	input  logic         s_tvalid,
	output logic         s_tready,
	// result_frame[4:0], result_found[5], in_set_count[11:6], zero pad [15:12]
	output logic [15:0]  m_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	localparam int FW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
	localparam int CW = $clog2(NUM_FRAMES + 1);
	localparam int XW = (FW > 5) ? FW : 5;
	localparam int KW = (CW > 6) ? CW : 6;
	localparam logic [CW-1:0] N_C   = CW'(NUM_FRAMES);
	localparam logic [FW-1:0] LAST_F = FW'(NUM_FRAMES - 1);

	// input fields
	logic [2:0]  in_func;
	logic [4:0]  in_idx;
	logic        in_occ, in_ref, in_mod;
	logic [15:0] in_page, in_pid;
	logic [31:0] in_last, in_now;

	assign in_func = s_tdata[2:0];
	assign in_idx  = s_tdata[7:3];
	assign in_occ  = s_tdata[8];
	assign in_page = s_tdata[24:9];
	assign in_pid  = s_tdata[40:25];
	assign in_ref  = s_tdata[41];
	assign in_mod  = s_tdata[42];
	assign in_last = s_tdata[74:43];
	assign in_now  = s_tdata[106:75];

	// configuration
	logic [1:0]  policy_q;
	logic [31:0] window_q;

	assign pready = 1'b1;
	always_comb begin
		prdata = {30'd0, policy_q};
		if (paddr[2] == pfru_pkg::REG_WINDOW) begin
			prdata = window_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= '0;
			window_q <= '0;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == pfru_pkg::REG_POLICY) begin
				policy_q <= pwdata[1:0];
			end else begin
				window_q <= pwdata;
			end
		end
	end

	// flag bits per frame
	logic [NUM_FRAMES-1:0] valid_q, ref_q, dirty_q;

	// control and work registers
	pfru_pkg::state_t st_q;
	logic [CW-1:0] cnt_q, n_q, hand_q, rank_q;
	logic [FW-1:0] pos_q, sel_q, idx_s1;
	logic          found_q, any_q, rd_vld_s1;
	logic [1:0]    best_cls_q;
	logic [31:0]   best_age_q;
	logic [CW-1:0] count_q;
	logic [15:0]   page_q, pid_q;
	logic [31:0]   now_q;
	logic          m_tvalid_q;
	logic [15:0]   m_tdata_q;

	// memory port
	logic [XW-1:0]                  widx_x;
	logic                           wr_ok, ram_we, issue;
	logic [pfru_pkg::ENTRY_W-1:0]   rd_data;
	logic [31:0]                    rd_age;
	logic                           rd_hit;
	logic [1:0]                     cur_cls;
	logic [FW-1:0]                  cur_f;
	logic                           accept;
	logic                           out_load;

	assign accept = s_tvalid && s_tready;
	assign s_tready = (st_q == pfru_pkg::ST_IDLE);
	assign widx_x = XW'(in_idx);
	assign wr_ok  = (32'(in_idx) < NUM_FRAMES);
	assign ram_we = accept && (in_func == pfru_pkg::FUNC_WRITE) && wr_ok;
	assign issue  = ((st_q == pfru_pkg::ST_FIND) || (st_q == pfru_pkg::ST_WSV)
		|| (st_q == pfru_pkg::ST_UPD)) && (cnt_q < N_C);
	assign cur_f  = cnt_q[FW-1:0];
	// load the output register when the result is ready and the slot is free
	assign out_load = (st_q == pfru_pkg::ST_DONE) && (!m_tvalid_q || m_tready);

	pfru_entry_ram #(
		.DEPTH(NUM_FRAMES),
		.AW   (FW),
		.DW   (pfru_pkg::ENTRY_W)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(widx_x[FW-1:0]),
		.wdata({in_page, in_pid, in_last}),
		.raddr(cur_f),
		.rdata(rd_data)
	);

	// compare the entry read out last cycle
	assign rd_age  = now_q - rd_data[31:0];
	assign rd_hit  = valid_q[idx_s1] && (rd_data[63:48] == page_q)
		&& (rd_data[47:32] == pid_q);
	assign cur_cls = {ref_q[cur_f], dirty_q[cur_f]};

	logic [XW-1:0] sel_x;
	logic [KW-1:0] count_x;
	assign sel_x   = XW'(sel_q);
	assign count_x = KW'(count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= pfru_pkg::ST_IDLE;
			valid_q    <= '0;
			ref_q      <= '0;
			dirty_q    <= '0;
			hand_q     <= '0;
			cnt_q      <= '0;
			rd_vld_s1  <= 1'b0;
			m_tvalid_q <= 1'b0;
			found_q    <= 1'b0;
			any_q      <= 1'b0;
		end else begin
			rd_vld_s1 <= issue;
			if (issue) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (st_q)
				pfru_pkg::ST_IDLE: begin
					if (accept) begin
						found_q <= 1'b0;
						any_q   <= 1'b0;
						cnt_q   <= '0;
						n_q     <= '0;
						count_q <= '0;
						sel_q   <= '0;
						st_q    <= pfru_pkg::ST_DONE;
						case (in_func)
							pfru_pkg::FUNC_WRITE: begin
								if (wr_ok) begin
									valid_q[widx_x[FW-1:0]] <= in_occ;
									ref_q[widx_x[FW-1:0]]   <= in_ref;
									dirty_q[widx_x[FW-1:0]] <= in_mod;
								end
							end
							pfru_pkg::FUNC_CLRREF: ref_q <= '0;
							pfru_pkg::FUNC_VICTIM: begin
								case (policy_q)
									pfru_pkg::POL_NRU:   st_q <= pfru_pkg::ST_NRU;
									pfru_pkg::POL_CLOCK: st_q <= pfru_pkg::ST_CCNT;
									pfru_pkg::POL_WSET:  st_q <= pfru_pkg::ST_WSV;
									default:             st_q <= pfru_pkg::ST_DONE;
								endcase
							end
							pfru_pkg::FUNC_UPDWS: st_q <= pfru_pkg::ST_UPD;
							pfru_pkg::FUNC_FIND:  st_q <= pfru_pkg::ST_FIND;
							default:              st_q <= pfru_pkg::ST_DONE;
						endcase
					end
				end
				pfru_pkg::ST_NRU: begin
					// keep the first frame of the lowest class
					if (cnt_q < N_C) begin
						if (valid_q[cur_f] && (!any_q || cur_cls < best_cls_q)) begin
							any_q      <= 1'b1;
							best_cls_q <= cur_cls;
							sel_q      <= cur_f;
						end
						cnt_q <= cnt_q + 1'b1;
					end else begin
						found_q <= any_q;
						st_q    <= pfru_pkg::ST_DONE;
					end
				end
				pfru_pkg::ST_FIND: begin
					if (rd_vld_s1 && rd_hit) begin
						found_q <= 1'b1;
						sel_q   <= idx_s1;
						st_q    <= pfru_pkg::ST_DONE;
					end else if (!issue && !rd_vld_s1) begin
						st_q <= pfru_pkg::ST_DONE;
					end
				end
				pfru_pkg::ST_WSV: begin
					if (rd_vld_s1 && valid_q[idx_s1] && rd_age > window_q) begin
						found_q <= 1'b1;
						sel_q   <= idx_s1;
						st_q    <= pfru_pkg::ST_DONE;
					end else if (rd_vld_s1 && valid_q[idx_s1]) begin
						if (!any_q || rd_age > best_age_q) begin
							any_q      <= 1'b1;
							best_age_q <= rd_age;
							sel_q      <= idx_s1;
						end
					end else if (!issue && !rd_vld_s1) begin
						found_q <= any_q;
						st_q    <= pfru_pkg::ST_DONE;
					end
				end
				pfru_pkg::ST_UPD: begin
					if (rd_vld_s1 && valid_q[idx_s1] && rd_age <= window_q) begin
						count_q <= count_q + 1'b1;
					end
					if (!issue && !rd_vld_s1) begin
						st_q <= pfru_pkg::ST_DONE;
					end
				end
				pfru_pkg::ST_CCNT: begin
					// count the ring size
					if (cnt_q < N_C) begin
						n_q   <= n_q + CW'(valid_q[cur_f]);
						cnt_q <= cnt_q + 1'b1;
					end else if (n_q == '0) begin
						st_q <= pfru_pkg::ST_DONE;
					end else begin
						st_q <= pfru_pkg::ST_CRED;
					end
				end
				pfru_pkg::ST_CRED: begin
					// hand modulo ring size by repeated subtraction
					if (hand_q >= n_q) begin
						hand_q <= hand_q - n_q;
					end else begin
						cnt_q  <= '0;
						rank_q <= '0;
						st_q   <= pfru_pkg::ST_CSEEK;
					end
				end
				pfru_pkg::ST_CSEEK: begin
					// find the frame at ring position hand
					cnt_q <= cnt_q + 1'b1;
					if (valid_q[cur_f]) begin
						if (rank_q == hand_q) begin
							pos_q <= cur_f;
							st_q  <= pfru_pkg::ST_CWALK;
						end
						rank_q <= rank_q + 1'b1;
					end
				end
				pfru_pkg::ST_CWALK: begin
					// second chance walk over occupied frames
					pos_q <= (pos_q == LAST_F) ? '0 : pos_q + 1'b1;
					if (valid_q[pos_q]) begin
						hand_q <= (hand_q + 1'b1 == n_q) ? '0 : hand_q + 1'b1;
						if (!ref_q[pos_q]) begin
							found_q <= 1'b1;
							sel_q   <= pos_q;
							st_q    <= pfru_pkg::ST_DONE;
						end else begin
							ref_q[pos_q] <= 1'b0;
						end
					end
				end
				pfru_pkg::ST_DONE: begin
					if (out_load) begin
						m_tdata_q  <= {4'd0, count_x[5:0], found_q,
							found_q ? sel_x[4:0] : 5'd0};
						st_q       <= pfru_pkg::ST_IDLE;
					end
				end
				default: st_q <= pfru_pkg::ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			page_q <= in_page;
			pid_q  <= in_pid;
			now_q  <= in_now;
		end
		idx_s1 <= cur_f;
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

// ===== rtl/pfru_entry_ram.sv =====
// Frame table memory: one write port, one registered read port.
module pfru_entry_ram #(
	parameter int DEPTH = pfru_pkg::NUM_FRAMES_DEF,
	parameter int AW    = 5,
	parameter int DW    = pfru_pkg::ENTRY_W
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== dv/tb_page_frame_replacement_unit_top.sv =====
// Self-checking testbench of the page frame replacement unit: directed and random items.
`timescale 1ns / 100ps

module tb_page_frame_replacement_unit_top;

	localparam int FRAMES = 32;
	localparam longint CYCLE_LIMIT = 2000000;

	logic         clk;
	logic         arst_n;
	logic [111:0] s_tdata;
	logic         s_tvalid;
	logic         s_tready;
	logic [15:0]  m_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic         psel;
	logic         penable;
	logic         pwrite;
	logic [2:0]   paddr;
	logic [31:0]  pwdata;
	logic [31:0]  prdata;
	logic         pready;

	// One request to the unit.
	typedef struct packed {
		logic [31:0] now;
		logic [31:0] last_use;
		logic        dirty;
		logic        refd;
		logic [15:0] pid;
		logic [15:0] page;
		logic        occ;
		logic [4:0]  idx;
		logic [2:0]  func;
	} req_t;

	// One answer of the unit.
	typedef struct packed {
		logic [5:0] count;
		logic       found;
		logic [4:0] frame;
	} ans_t;

	// Predicted frame table and registers.
	logic        pt_valid [FRAMES];
	logic [15:0] pt_page  [FRAMES];
	logic [15:0] pt_owner [FRAMES];
	logic        pt_ref   [FRAMES];
	logic        pt_dirty [FRAMES];
	logic [31:0] pt_last  [FRAMES];
	logic        pt_inset [FRAMES];
	int unsigned pt_hand;
	logic [1:0]  cur_policy;
	logic [31:0] cur_window;

	ans_t   answers_due[$];
	int     errors;
	int     items_sent;
	int     answers_seen;
	longint cycles;

	page_frame_replacement_unit_top u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
		.m_tdata(m_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Watchdog: count cycles and end the run if it hangs.
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("timeout at %0t", $time);
				$display("tb_page_frame_replacement_unit_top NOT OK");
				$finish;
			end
		end
	end

	// Compute the answer of one request and advance the predicted table.
	function automatic ans_t predict_answer(req_t r);
		ans_t a;
		int unsigned ring [FRAMES];
		int unsigned n;
		int unsigned m;
		logic [31:0] age;
		logic [31:0] best_age;
		logic        any;
		logic        done;
		a = '0;
		done = 1'b0;
		case (r.func)
			pfru_pkg::FUNC_WRITE: begin
				pt_valid[r.idx] = r.occ;
				pt_page[r.idx]  = r.page;
				pt_owner[r.idx] = r.pid;
				pt_ref[r.idx]   = r.refd;
				pt_dirty[r.idx] = r.dirty;
				pt_last[r.idx]  = r.last_use;
			end
			pfru_pkg::FUNC_CLRREF: begin
				for (int f = 0; f < FRAMES; f++) pt_ref[f] = 1'b0;
			end
			pfru_pkg::FUNC_VICTIM: begin
				if (cur_policy == pfru_pkg::POL_NRU) begin
					for (int c = 0; c < 4 && !done; c++)
						for (int f = 0; f < FRAMES && !done; f++)
							if (pt_valid[f] && (pt_ref[f] * 2 + pt_dirty[f]) == c) begin
								a.frame = 5'(f);
								a.found = 1'b1;
								done = 1'b1;
							end
				end else if (cur_policy == pfru_pkg::POL_CLOCK) begin
					n = 0;
					for (int f = 0; f < FRAMES; f++)
						if (pt_valid[f]) begin
							ring[n] = f;
							n++;
						end
					if (n != 0) begin
						pt_hand = pt_hand % n;
						a.found = 1'b1;
						for (int i = 0; i < 2 * n && !done; i++) begin
							m = ring[pt_hand];
							pt_hand = (pt_hand + 1) % n;
							if (!pt_ref[m]) begin
								a.frame = 5'(m);
								done = 1'b1;
							end else begin
								pt_ref[m] = 1'b0;
							end
						end
						if (!done) a.frame = 5'(ring[pt_hand]);
					end
				end else if (cur_policy == pfru_pkg::POL_WSET) begin
					any = 1'b0;
					best_age = '0;
					for (int f = 0; f < FRAMES && !done; f++)
						if (pt_valid[f]) begin
							age = r.now - pt_last[f];
							if (age > cur_window) begin
								a.frame = 5'(f);
								done = 1'b1;
							end else if (!any || age > best_age) begin
								any = 1'b1;
								a.frame = 5'(f);
								best_age = age;
							end
						end
					a.found = done | any;
				end
			end
			pfru_pkg::FUNC_UPDWS: begin
				for (int f = 0; f < FRAMES; f++) begin
					age = r.now - pt_last[f];
					pt_inset[f] = pt_valid[f] && age <= cur_window;
					if (pt_inset[f]) a.count++;
				end
			end
			pfru_pkg::FUNC_FIND: begin
				for (int f = 0; f < FRAMES && !done; f++)
					if (pt_valid[f] && pt_page[f] == r.page && pt_owner[f] == r.pid) begin
						a.frame = 5'(f);
						a.found = 1'b1;
						done = 1'b1;
					end
			end
			default: ;
		endcase
		if (!a.found) a.frame = '0;
		return a;
	endfunction

	// Send one request; the answer is predicted when the unit takes it.
	// Enter and leave at a falling edge; drop tvalid only when a gap follows.
	task automatic send_request(req_t r);
		int gap;
		gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tdata  <= {5'd0, r};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		answers_due.push_back(predict_answer(r));
		items_sent++;
		@(negedge clk);
	endtask

	// Compare every answer with the oldest prediction.
	initial begin
		ans_t got;
		ans_t want;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				got = m_tdata[11:0];
				answers_seen++;
				if (answers_due.size() == 0) begin
					$display("%0t: unexpected answer %h", $time, got);
					errors++;
				end else begin
					want = answers_due.pop_front();
					if (got.frame !== want.frame)
						$display("%0t: frame exp %0d got %0d", $time, want.frame, got.frame);
					if (got.found !== want.found)
						$display("%0t: found exp %0d got %0d", $time, want.found, got.found);
					if (got.count !== want.count)
						$display("%0t: count exp %0d got %0d", $time, want.count, got.count);
					if (got !== want) errors++;
				end
			end
		end
	end

	// Random receiver stalls, with calm stretches.
	initial begin
		int hold;
		m_tready = 1'b1;
		forever begin
			@(negedge clk);
			if ($urandom_range(0, 199) < 3) begin
				m_tready <= 1'b1;
				repeat ($urandom_range(20, 80)) @(negedge clk);
			end
			hold = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
			if (hold != 0) begin
				m_tready <= 1'b0;
				repeat (hold) @(negedge clk);
				m_tready <= 1'b1;
			end
		end
	end

	// Hold the sender until every answer has come, then let the unit settle.
	task automatic drain_answers();
		s_tvalid <= 1'b0;
		while (answers_due.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_register(logic reg_sel, logic [31:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		paddr   <= {reg_sel, 2'b00};
		pwdata  <= value;
		penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (reg_sel == pfru_pkg::REG_POLICY) cur_policy = value[1:0];
		else cur_window = value;
	endtask

	task automatic set_policy(logic [1:0] pol, logic [31:0] win);
		drain_answers();
		write_register(pfru_pkg::REG_POLICY, {30'd0, pol});
		write_register(pfru_pkg::REG_WINDOW, win);
	endtask

	function automatic req_t random_request(int pool);
		req_t r;
		r.func     = pfru_pkg::FUNC_WRITE + 3'($urandom_range(0, 4));
		r.idx      = 5'($urandom_range(0, 31));
		r.occ      = $urandom_range(0, 3) != 0;
		r.page     = 16'($urandom_range(0, pool));
		r.pid      = 16'($urandom_range(0, 3));
		if ($urandom_range(0, 15) == 0) begin
			r.page = 16'($urandom);
			r.pid  = 16'($urandom);
		end
		r.refd     = 1'($urandom);
		r.dirty    = 1'($urandom);
		r.last_use = $urandom_range(0, 400);
		r.now      = $urandom_range(0, 500);
		if ($urandom_range(0, 9) == 0) begin
			r.last_use = $urandom;
			r.now      = $urandom;
		end
		return r;
	endfunction

	// Extremes of the fields, every item kind, empty table and wraparound ages.
	task automatic test_directed();
		req_t r;
		set_policy(pfru_pkg::POL_NRU, 32'd0);
		// empty table: victim and find answer nothing
		r = '0; r.func = pfru_pkg::FUNC_VICTIM; send_request(r);
		r.func = pfru_pkg::FUNC_FIND; send_request(r);
		r.func = pfru_pkg::FUNC_UPDWS; r.now = '1; send_request(r);
		r = '1; r.func = pfru_pkg::FUNC_WRITE; send_request(r);
		r = '0; r.func = pfru_pkg::FUNC_WRITE; r.occ = 1; r.refd = 1; send_request(r);
		r.idx = 5; r.dirty = 1; r.refd = 0; r.page = 16'h1234; r.pid = 16'hffff;
		send_request(r);
		r = '1; r.func = pfru_pkg::FUNC_FIND; send_request(r);
		r = '0; r.func = pfru_pkg::FUNC_FIND; r.page = 16'h1234; r.pid = 16'hffff;
		send_request(r);
		r.func = pfru_pkg::FUNC_VICTIM; send_request(r);
		r.func = 3'd5; send_request(r);
		r.func = 3'd7; send_request(r);
		r.func = pfru_pkg::FUNC_CLRREF; send_request(r);
		r.func = pfru_pkg::FUNC_VICTIM; send_request(r);
		set_policy(pfru_pkg::POL_CLOCK, 32'd0);
		r = '0; r.func = pfru_pkg::FUNC_VICTIM; send_request(r);
		send_request(r);
		set_policy(pfru_pkg::POL_WSET, 32'hffff_ffff);
		r = '0; r.func = pfru_pkg::FUNC_VICTIM; r.now = 32'd3; send_request(r);
		r.func = pfru_pkg::FUNC_UPDWS; send_request(r);
		set_policy(pfru_pkg::POL_WSET, 32'd0);
		r = '0; r.func = pfru_pkg::FUNC_VICTIM; r.now = 32'hffff_ffff; send_request(r);
		r.func = pfru_pkg::FUNC_UPDWS; send_request(r);
		set_policy(2'd3, 32'd0);
		r = '0; r.func = pfru_pkg::FUNC_VICTIM; send_request(r);
	endtask

	// Random phases under every policy and window setting.
	task automatic test_random();
		logic [31:0] win;
		for (int ph = 0; ph < 16; ph++) begin
			case (ph % 4)
				0: win = 32'd0;
				1: win = $urandom_range(50, 300);
				2: win = 32'hffff_ffff;
				default: win = $urandom;
			endcase
			set_policy(ph % 4 == 3 && ph > 12 ? 2'd3 : 2'(ph % 3), win);
			for (int i = 0; i < 50; i++) send_request(random_request(7));
		end
	endtask

	initial begin
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		errors = 0; items_sent = 0; answers_seen = 0;
		cur_policy = pfru_pkg::POL_NRU; cur_window = '0; pt_hand = 0;
		for (int f = 0; f < FRAMES; f++) begin
			pt_valid[f] = 0; pt_page[f] = 0; pt_owner[f] = 0; pt_ref[f] = 0;
			pt_dirty[f] = 0; pt_last[f] = 0; pt_inset[f] = 0;
		end
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_random();
		drain_answers();
		repeat (200) @(negedge clk);
		$display("sent %0d items, checked %0d answers over all victim policies",
			items_sent, answers_seen);
		if (errors == 0 && answers_due.size() == 0)
			$display("tb_page_frame_replacement_unit_top OK");
		else
			$display("tb_page_frame_replacement_unit_top NOT OK");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/pfru_pkg.sv
rtl/pfru_entry_ram.sv
rtl/page_frame_replacement_unit_top.sv
dv/tb_page_frame_replacement_unit_top.sv
